>>> rtl/nprp_pkg.sv
`default_nettype none
package nprp_pkg;

    localparam int ADDR_W     = 48;
    localparam int COUNT_W    = 17;
    localparam int LEN_W      = 16;
    localparam int SHIFT_W    = 4;
    localparam int LIMIT_W    = 6;
    localparam int DEPTH_W    = 11;
    localparam int CID_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int PAGE_SHIFT       = 12;
    localparam int PAGE_BYTES       = 1 << PAGE_SHIFT;
    localparam int MAX_LIST_ENTRIES = 32;
    localparam int MAX_BLOCKS       = 65536;
    localparam int MAX_DEPTH        = 1024;
    localparam int ENTRY_BYTES_LOG2 = 3;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 176;

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_CMD   = 2'd1,
        KIND_ERR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_MANY = 2'd1,
        ERR_BEYOND   = 2'd2
    } err_t;

    localparam logic [1:0] OP_WRITE = 2'h1;
    localparam logic [1:0] OP_READ  = 2'h2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLK_SHIFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NS_BLOCKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DEPTH = 3'd4;

    typedef struct packed {
        logic [SHIFT_W-1:0] blk_shift;
        logic [ADDR_W-1:0]  namespace_blocks;
        logic [LIMIT_W-1:0] max_list_entries;
        logic [ADDR_W-1:0]  list_region_base;
        logic [DEPTH_W-1:0] queue_depth;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic check;
        logic clip;
        logic size;
        logic emit_entry;
        logic emit_cmd;
        logic emit_err;
    } dp_cmd_t;

    typedef struct packed {
        logic beyond;
        logic too_many;
        logic has_entries;
        logic last_entry;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/nprp_cfg.sv
`default_nettype none
module nprp_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [nprp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nprp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output nprp_pkg::cfg_t                         cfg
);

    nprp_pkg::cfg_t cfg_reg;
    nprp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                nprp_pkg::CFG_BLK_SHIFT:
                    cfg_next.blk_shift = cfg_data[nprp_pkg::SHIFT_W-1:0];
                nprp_pkg::CFG_NS_BLOCKS:
                    cfg_next.namespace_blocks = cfg_data[nprp_pkg::ADDR_W-1:0];
                nprp_pkg::CFG_MAX_ENTRIES:
                    cfg_next.max_list_entries = cfg_data[nprp_pkg::LIMIT_W-1:0];
                nprp_pkg::CFG_LIST_BASE:
                    cfg_next.list_region_base = cfg_data[nprp_pkg::ADDR_W-1:0];
                nprp_pkg::CFG_QUEUE_DEPTH:
                    cfg_next.queue_depth = cfg_data[nprp_pkg::DEPTH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blk_shift        <= nprp_pkg::SHIFT_W'(9);
            cfg_reg.namespace_blocks <= '0;
            cfg_reg.max_list_entries <= nprp_pkg::LIMIT_W'(32);
            cfg_reg.list_region_base <= '0;
            cfg_reg.queue_depth      <= nprp_pkg::DEPTH_W'(64);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/nprp_ctrl.sv
`default_nettype none
module nprp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire nprp_pkg::dp_status_t status,
    output nprp_pkg::dp_cmd_t         command
);

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_CHECK      = 7'b0000010,
        ST_CLIP       = 7'b0000100,
        ST_SIZE       = 7'b0001000,
        ST_DECIDE     = 7'b0010000,
        ST_EMIT_ENTRY = 7'b0100000,
        ST_EMIT_TAIL  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   tail_err_reg;
    logic   tail_err_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        tail_err_next = tail_err_reg;
        command       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    command.load_in = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                command.check = 1'b1;
                state_next    = ST_CLIP;
            end
            ST_CLIP:
            begin
                command.clip = 1'b1;
                if (status.beyond)
                begin
                    tail_err_next = 1'b1;
                    state_next    = ST_EMIT_TAIL;
                end
                else
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                command.size = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                priority if (status.too_many)
                begin
                    tail_err_next = 1'b1;
                    state_next    = ST_EMIT_TAIL;
                end
                else if (status.has_entries)
                begin
                    state_next = ST_EMIT_ENTRY;
                end
                else
                begin
                    tail_err_next = 1'b0;
                    state_next    = ST_EMIT_TAIL;
                end
            end
            ST_EMIT_ENTRY:
            begin
                if (status.out_free)
                begin
                    command.emit_entry = 1'b1;
                    if (status.last_entry)
                    begin
                        tail_err_next = 1'b0;
                        state_next    = ST_EMIT_TAIL;
                    end
                end
            end
            ST_EMIT_TAIL:
            begin
                if (status.out_free)
                begin
                    command.emit_err = tail_err_reg;
                    command.emit_cmd = !tail_err_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tail_err_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tail_err_reg <= tail_err_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/nprp_dp.sv
`default_nettype none
module nprp_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire nprp_pkg::cfg_t                  cfg,
    input  wire nprp_pkg::dp_cmd_t               command,
    output nprp_pkg::dp_status_t                 status,
    input  wire logic [nprp_pkg::ADDR_W-1:0]     in_buffer_address,
    input  wire logic [nprp_pkg::ADDR_W-1:0]     in_start_block,
    input  wire logic [nprp_pkg::COUNT_W-1:0]    in_block_count,
    input  wire logic                            in_is_write,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           out_kind,
    output logic [nprp_pkg::ADDR_W-1:0]          out_address,
    output logic [nprp_pkg::ADDR_W-1:0]          out_second_address,
    output logic [nprp_pkg::ADDR_W-1:0]          out_slba,
    output logic [nprp_pkg::LEN_W-1:0]           out_length_minus_one,
    output logic [1:0]                           out_opcode,
    output logic [nprp_pkg::CID_W-1:0]           out_slot_id,
    output logic [1:0]                           out_error_code,
    output logic                                 out_last
);

    localparam int AW = nprp_pkg::ADDR_W;
    localparam int CW = nprp_pkg::COUNT_W;
    localparam int LW = nprp_pkg::LIMIT_W;
    localparam int BYTES_W = CW + 16;
    localparam int PROD_W  = nprp_pkg::CID_W + LW;
    localparam logic [AW-1:0] PAGE_MASK = ~AW'(nprp_pkg::PAGE_BYTES - 1);

    // request registers
    logic [AW-1:0]  buf_reg, buf_next;
    logic [AW-1:0]  start_reg, start_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           write_reg, write_next;
    logic [AW-1:0]  diff_reg, diff_next;
    logic           beyond_reg, beyond_next;
    logic [AW-1:0]  list_addr_reg, list_addr_next;
    logic [AW-1:0]  prp2_reg, prp2_next;
    logic           too_many_reg, too_many_next;
    logic           has_entries_reg, has_entries_next;
    logic [LW-1:0]  left_reg, left_next;
    logic [AW-1:0]  entry_addr_reg, entry_addr_next;
    logic [nprp_pkg::CID_W-1:0] counter_reg, counter_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            kind_reg, kind_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [AW-1:0]         addr2_reg, addr2_next;
    logic [AW-1:0]         slba_reg, slba_next;
    logic [nprp_pkg::LEN_W-1:0] lm1_reg, lm1_next;
    logic [1:0]            op_reg, op_next;
    logic [nprp_pkg::CID_W-1:0] cid_reg, cid_next;
    logic [1:0]            err_reg, err_next;
    logic                  last_reg, last_next;

    // combinational helpers
    logic [CW-1:0]      count_in;
    logic [AW:0]        diff_w;
    logic [LW-1:0]      limit;
    logic [PROD_W-1:0]  slot_prod;
    logic [CW-1:0]      count_m1;
    logic [BYTES_W-1:0] bytes_w;
    logic [BYTES_W-1:0] bytes_m1_w;
    logic [BYTES_W-1:0] n_w;
    logic               fits_one;
    logic               fits_two;
    logic [AW-1:0]      aligned;
    logic [nprp_pkg::DEPTH_W-1:0] depth;
    logic [nprp_pkg::DEPTH_W-1:0] cid_inc;

    always_comb
    begin
        priority if (in_block_count == '0)
            count_in = CW'(1);
        else if (in_block_count > CW'(nprp_pkg::MAX_BLOCKS))
            count_in = CW'(nprp_pkg::MAX_BLOCKS);
        else
            count_in = in_block_count;
    end

    assign diff_w    = {1'b0, cfg.namespace_blocks} - {1'b0, start_reg};
    assign limit     = (cfg.max_list_entries > LW'(nprp_pkg::MAX_LIST_ENTRIES))
                       ? LW'(nprp_pkg::MAX_LIST_ENTRIES) : cfg.max_list_entries;
    assign slot_prod = counter_reg * limit;
    assign count_m1  = count_reg - CW'(1);
    assign bytes_w    = BYTES_W'(count_reg) << cfg.blk_shift;
    assign bytes_m1_w = BYTES_W'(count_m1) << cfg.blk_shift;
    assign n_w        = bytes_m1_w >> nprp_pkg::PAGE_SHIFT;
    assign fits_one   = bytes_w <= BYTES_W'(nprp_pkg::PAGE_BYTES);
    assign fits_two   = bytes_w <= BYTES_W'(2 * nprp_pkg::PAGE_BYTES);
    assign aligned    = buf_reg & PAGE_MASK;
    assign depth      = (cfg.queue_depth > nprp_pkg::DEPTH_W'(nprp_pkg::MAX_DEPTH))
                        ? nprp_pkg::DEPTH_W'(nprp_pkg::MAX_DEPTH) : cfg.queue_depth;
    assign cid_inc    = {1'b0, counter_reg} + nprp_pkg::DEPTH_W'(1);

    assign status.beyond      = beyond_reg;
    assign status.too_many    = too_many_reg;
    assign status.has_entries = has_entries_reg;
    assign status.last_entry  = (left_reg == LW'(1));
    assign status.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        buf_next         = buf_reg;
        start_next       = start_reg;
        count_next       = count_reg;
        write_next       = write_reg;
        diff_next        = diff_reg;
        beyond_next      = beyond_reg;
        list_addr_next   = list_addr_reg;
        prp2_next        = prp2_reg;
        too_many_next    = too_many_reg;
        has_entries_next = has_entries_reg;
        left_next        = left_reg;
        entry_addr_next  = entry_addr_reg;
        counter_next     = counter_reg;

        if (command.load_in)
        begin
            buf_next   = in_buffer_address;
            start_next = in_start_block;
            count_next = count_in;
            write_next = in_is_write;
        end

        if (command.check)
        begin
            diff_next      = diff_w[AW-1:0];
            beyond_next    = diff_w[AW] || (diff_w == '0);
            list_addr_next = cfg.list_region_base
                             + AW'({slot_prod, {nprp_pkg::ENTRY_BYTES_LOG2{1'b0}}});
        end

        // clip at the namespace end; the clipped count is only used when the start lies below the end
        if (command.clip && (AW'(count_reg) >= diff_reg))
        begin
            count_next = diff_reg[CW-1:0];
        end

        if (command.size)
        begin
            too_many_next    = !fits_two && (n_w > BYTES_W'(limit));
            has_entries_next = !fits_two && (n_w != '0);
            left_next        = n_w[LW-1:0];
            entry_addr_next  = aligned + AW'(nprp_pkg::PAGE_BYTES);
            priority if (fits_one)
                prp2_next = '0;
            else if (fits_two)
                prp2_next = aligned + AW'(nprp_pkg::PAGE_BYTES);
            else
                prp2_next = list_addr_reg;
        end

        if (command.emit_entry)
        begin
            entry_addr_next = entry_addr_reg + AW'(nprp_pkg::PAGE_BYTES);
            left_next       = left_reg - LW'(1);
        end

        if (command.emit_cmd)
        begin
            counter_next = (cid_inc >= depth) ? '0 : cid_inc[nprp_pkg::CID_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        addr2_next     = addr2_reg;
        slba_next      = slba_reg;
        lm1_next       = lm1_reg;
        op_next        = op_reg;
        cid_next       = cid_reg;
        err_next       = err_reg;
        last_next      = last_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        priority if (command.emit_entry)
        begin
            out_valid_next = 1'b1;
            kind_next      = nprp_pkg::KIND_ENTRY;
            addr_next      = entry_addr_reg;
            addr2_next     = '0;
            slba_next      = '0;
            lm1_next       = '0;
            op_next        = '0;
            cid_next       = counter_reg;
            err_next       = nprp_pkg::ERR_NONE;
            last_next      = 1'b0;
        end
        else if (command.emit_cmd)
        begin
            out_valid_next = 1'b1;
            kind_next      = nprp_pkg::KIND_CMD;
            addr_next      = buf_reg;
            addr2_next     = prp2_reg;
            slba_next      = start_reg;
            lm1_next       = count_m1[nprp_pkg::LEN_W-1:0];
            op_next        = write_reg ? nprp_pkg::OP_WRITE : nprp_pkg::OP_READ;
            cid_next       = counter_reg;
            err_next       = nprp_pkg::ERR_NONE;
            last_next      = 1'b1;
        end
        else if (command.emit_err)
        begin
            out_valid_next = 1'b1;
            kind_next      = nprp_pkg::KIND_ERR;
            addr_next      = '0;
            addr2_next     = '0;
            slba_next      = '0;
            lm1_next       = '0;
            op_next        = '0;
            cid_next       = '0;
            // the namespace check runs first, so its flag wins
            err_next       = beyond_reg ? nprp_pkg::ERR_BEYOND : nprp_pkg::ERR_TOO_MANY;
            last_next      = 1'b1;
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg         <= buf_next;
        start_reg       <= start_next;
        count_reg       <= count_next;
        write_reg       <= write_next;
        diff_reg        <= diff_next;
        beyond_reg      <= beyond_next;
        list_addr_reg   <= list_addr_next;
        prp2_reg        <= prp2_next;
        too_many_reg    <= too_many_next;
        has_entries_reg <= has_entries_next;
        left_reg        <= left_next;
        entry_addr_reg  <= entry_addr_next;
        kind_reg        <= kind_next;
        addr_reg        <= addr_next;
        addr2_reg       <= addr2_next;
        slba_reg        <= slba_next;
        lm1_reg         <= lm1_next;
        op_reg          <= op_next;
        cid_reg         <= cid_next;
        err_reg         <= err_next;
        last_reg        <= last_next;
    end

    assign out_valid            = out_valid_reg;
    assign out_kind             = kind_reg;
    assign out_address          = addr_reg;
    assign out_second_address   = addr2_reg;
    assign out_slba             = slba_reg;
    assign out_length_minus_one = lm1_reg;
    assign out_opcode           = op_reg;
    assign out_slot_id          = cid_reg;
    assign out_error_code       = err_reg;
    assign out_last             = last_reg;

endmodule
`default_nettype wire

>>> rtl/nvme_prp_read_write_builder_top.sv
`default_nettype none
// Turns each transfer request into an NVMe read or write command. Requests
// whose transfer spans more than two pages first produce one PRP list entry
// word per page beyond the first, then the command word, which carries tlast;
// a start at or past the namespace end, or a list longer than the per-slot
// limit, produces a single error word instead. A request passes five setup
// steps (accept, namespace check, clip, sizing, dispatch) and then sends its
// result words through the single output register, one per cycle while that
// register is not held full; a start beyond the namespace end skips sizing
// and dispatch. The next request is accepted as soon as the final word sits
// in the output register. Configuration writes are taken in any cycle but
// must only be issued while no request is in flight.
module nvme_prp_read_write_builder_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [47:0] buffer_address, [95:48] start_block, [112:96] block_count, rest zero
    input  wire logic [nprp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] is_write
    input  wire logic [0:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [47:0] address, [95:48] second_address, [143:96] slba,
    // [159:144] length_minus_one, [161:160] opcode, [171:162] slot number,
    // [173:172] error_code, rest zero
    output logic [nprp_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // [1:0] kind
    output logic [1:0]                               m_axis_tuser,
    output logic                                     m_axis_tlast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [nprp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [nprp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    nprp_pkg::cfg_t       cfg;
    nprp_pkg::dp_cmd_t    command;
    nprp_pkg::dp_status_t status;

    logic [nprp_pkg::ADDR_W-1:0] out_address;
    logic [nprp_pkg::ADDR_W-1:0] out_second_address;
    logic [nprp_pkg::ADDR_W-1:0] out_slba;
    logic [nprp_pkg::LEN_W-1:0]  out_length_minus_one;
    logic [1:0]                  out_opcode;
    logic [nprp_pkg::CID_W-1:0]  out_slot_id;
    logic [1:0]                  out_error_code;

    nprp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nprp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .command  (command)
    );

    nprp_dp u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg),
        .command              (command),
        .status               (status),
        .in_buffer_address    (s_axis_tdata[47:0]),
        .in_start_block       (s_axis_tdata[95:48]),
        .in_block_count       (s_axis_tdata[112:96]),
        .in_is_write          (s_axis_tuser[0]),
        .out_valid            (m_axis_tvalid),
        .out_ready            (m_axis_tready),
        .out_kind             (m_axis_tuser),
        .out_address          (out_address),
        .out_second_address   (out_second_address),
        .out_slba             (out_slba),
        .out_length_minus_one (out_length_minus_one),
        .out_opcode           (out_opcode),
        .out_slot_id          (out_slot_id),
        .out_error_code       (out_error_code),
        .out_last             (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_error_code, out_slot_id, out_opcode,
                           out_length_minus_one, out_slba, out_second_address,
                           out_address};

    // a request keeps the input closed through its setup steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again right after a request");

    // list entries never close a request, errors always do
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == nprp_pkg::KIND_ENTRY)) |-> !m_axis_tlast)
        else $error("list entry word marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == nprp_pkg::KIND_ERR))
            |-> (m_axis_tlast && (out_error_code != nprp_pkg::ERR_NONE)))
        else $error("error word without last or without a code");

endmodule
`default_nettype wire
